@@ rtl/pit_pkg.sv @@
// shared constants and helpers for the point-in-triangle area test
package pit_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int VERTEX_WIDTH    = 48;
  localparam int TOL_WIDTH       = 16;
  localparam int CFG_IDX_WIDTH   = 8;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_A  = 8'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_B  = 8'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_VERTEX_C  = 8'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TOLERANCE = 8'd3;

  // root width of a cross magnitude for a given coordinate width
  function automatic int root_width(input int w);
    return 2 * w + 3;
  endfunction

  // product, magnitude, partial square, square, radicand, then one stage per root bit
  function automatic int norm_latency(input int w);
    return 5 + root_width(w);
  endfunction

endpackage

@@ rtl/pit_cross_norm.sv @@
// pipelined floor magnitude of the cross product of two small vectors
module pit_cross_norm #(
  parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            en,
  input  logic signed [COORD_WIDTH:0]                     u [3],
  input  logic signed [COORD_WIDTH:0]                     v [3],
  output logic [pit_pkg::root_width(COORD_WIDTH)-1:0]     norm
);

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2 * W + 2;
  localparam int MW  = 2 * W + 2;
  localparam int L   = W + 1;
  localparam int H   = MW - L;
  localparam int SW  = 2 * MW;
  localparam int R   = pit_pkg::root_width(W);
  localparam int NW  = 2 * R;

  logic signed [PW-1:0] prod [6];
  logic [MW-1:0]        mag [3];
  logic [2*H-1:0]       phh [3];
  logic [H+L-1:0]       phl [3];
  logic [2*L-1:0]       pll [3];
  logic [SW-1:0]        sq [3];
  logic [NW-1:0]        rad;

  logic [R+1:0]  rem  [R+1];
  logic [R-1:0]  root [R+1];
  logic [NW-1:0] rest [R+1];

  always_ff @(posedge clk) begin
    if (en) begin
      prod[0] <= PW'(u[1] * v[2]);
      prod[1] <= PW'(u[2] * v[1]);
      prod[2] <= PW'(u[2] * v[0]);
      prod[3] <= PW'(u[0] * v[2]);
      prod[4] <= PW'(u[0] * v[1]);
      prod[5] <= PW'(u[1] * v[0]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_comp
    logic signed [PW:0] cd;
    assign cd = (PW+1)'(prod[2*k]) - (PW+1)'(prod[2*k+1]);

    always_ff @(posedge clk) begin
      if (en) begin
        mag[k] <= cd[PW] ? MW'(-cd) : MW'(cd);
        // square split in halves to keep each multiplier narrow
        phh[k] <= (2*H)'(mag[k][MW-1:L] * mag[k][MW-1:L]);
        phl[k] <= (H+L)'(mag[k][MW-1:L] * mag[k][L-1:0]);
        pll[k] <= (2*L)'(mag[k][L-1:0] * mag[k][L-1:0]);
        sq[k]  <= (SW'(phh[k]) << (2*L)) + (SW'(phl[k]) << (L+1)) + SW'(pll[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= NW'(sq[0]) + NW'(sq[1]) + NW'(sq[2]);
    end
  end

  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rest[0] = rad;

  // digit-by-digit root, one result bit per stage
  for (genvar i = 0; i < R; i++) begin : g_sqrt
    logic [R+1:0] cur;
    logic [R+1:0] trial;
    assign cur   = {rem[i][R-1:0], rest[i][NW-1:NW-2]};
    assign trial = {root[i], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rest[i+1] <= rest[i] << 2;
        if (cur >= trial) begin
          rem[i+1]  <= cur - trial;
          root[i+1] <= {root[i][R-2:0], 1'b1};
        end else begin
          rem[i+1]  <= cur;
          root[i+1] <= {root[i][R-2:0], 1'b0};
        end
      end
    end
  end

  assign norm = root[R];

endmodule

@@ rtl/point_in_triangle_area_test.sv @@
// point-in-triangle area test: top level with configuration, stall control and compare
//
// One point is accepted per cycle while the output is not stalled, and its
// answer passes through one stage for the edge vectors, five for products,
// magnitudes, squares and the radicand sum, one per root bit in the
// square-root pipelines, and one for the final compare.
// The whole pipeline stalls as one while a result waits on m_tready, so nothing
// is dropped or repeated. The triangle and tolerance come from the cfg port and
// are to be written only while no item is in flight.
module point_in_triangle_area_test #(
  parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // point_x, point_y, point_z from bit 0, zero padded
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // inside_res at bit 0, zero padded
  output logic [7:0]                             m_tdata,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [pit_pkg::CFG_IDX_WIDTH-1:0]      cfg_index,
  input  logic [pit_pkg::VERTEX_WIDTH-1:0]       cfg_data
);

  localparam int W    = COORD_WIDTH;
  localparam int VW   = pit_pkg::VERTEX_WIDTH;
  localparam int VEXT = (3 * W > VW) ? 3 * W : VW;
  localparam int R    = pit_pkg::root_width(W);
  localparam int LAT  = pit_pkg::norm_latency(W);

  logic [VW-1:0]                    vertex_a;
  logic [VW-1:0]                    vertex_b;
  logic [VW-1:0]                    vertex_c;
  logic [pit_pkg::TOL_WIDTH-1:0]    tolerance;

  logic en;
  logic v1;
  logic [LAT-1:0] vpipe;
  logic hit;

  logic [VEXT-1:0] ea, eb, ec;
  logic signed [W:0] pa [3], pb [3], pc [3], ab [3], ac [3];
  logic [R-1:0] n_ab, n_ac, n_bc, n_tri;
  logic [R+1:0] nsum, limit;

  assign cfg_ready = 1'b1;
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign m_tdata   = {7'b0, hit};

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_a  <= '0;
      vertex_b  <= VW'(256);
      vertex_c  <= VW'(256) << W;
      tolerance <= pit_pkg::TOL_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pit_pkg::REG_VERTEX_A:  vertex_a  <= cfg_data;
        pit_pkg::REG_VERTEX_B:  vertex_b  <= cfg_data;
        pit_pkg::REG_VERTEX_C:  vertex_c  <= cfg_data;
        pit_pkg::REG_TOLERANCE: tolerance <= cfg_data[pit_pkg::TOL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // coordinates beyond the 48 packed bits read as zero
  assign ea = VEXT'(vertex_a);
  assign eb = VEXT'(vertex_b);
  assign ec = VEXT'(vertex_c);

  for (genvar k = 0; k < 3; k++) begin : g_diff
    logic signed [W-1:0] p, a, b, c;
    assign p = s_tdata[k*W +: W];
    assign a = ea[k*W +: W];
    assign b = eb[k*W +: W];
    assign c = ec[k*W +: W];

    always_ff @(posedge clk) begin
      if (en) begin
        pa[k] <= (W+1)'(a) - (W+1)'(p);
        pb[k] <= (W+1)'(b) - (W+1)'(p);
        pc[k] <= (W+1)'(c) - (W+1)'(p);
        ab[k] <= (W+1)'(b) - (W+1)'(a);
        ac[k] <= (W+1)'(c) - (W+1)'(a);
      end
    end
  end

  pit_cross_norm #(.COORD_WIDTH(W)) u_norm_ab (
    .clk(clk), .en(en), .u(pa), .v(pb), .norm(n_ab));
  pit_cross_norm #(.COORD_WIDTH(W)) u_norm_ac (
    .clk(clk), .en(en), .u(pa), .v(pc), .norm(n_ac));
  pit_cross_norm #(.COORD_WIDTH(W)) u_norm_bc (
    .clk(clk), .en(en), .u(pb), .v(pc), .norm(n_bc));
  pit_cross_norm #(.COORD_WIDTH(W)) u_norm_tri (
    .clk(clk), .en(en), .u(ab), .v(ac), .norm(n_tri));

  assign nsum  = (R+2)'(n_ab) + (R+2)'(n_ac) + (R+2)'(n_bc);
  assign limit = (R+2)'(n_tri) + (R+2)'(tolerance);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      vpipe    <= '0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      v1       <= s_tvalid;
      vpipe    <= {vpipe[LAT-2:0], v1};
      m_tvalid <= vpipe[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit <= (nsum <= limit);
    end
  end

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while result stalled");

  a_last_stage_to_output: assert property (@(posedge clk) disable iff (rst)
    (vpipe[LAT-1] && en) |=> m_tvalid)
    else $error("item lost at output register");

  a_held_under_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(hit)))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && vpipe == '0 && !v1))
    else $error("pipeline not empty after reset");

endmodule
